// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/crc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_pkg
// shared types and constants of the climate relay controller
// ----------------------------------------------------------------------------
package crc_pkg;

  localparam logic [7:0] CHAR_M  = 8'h4D;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_1  = 8'h31;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] MASK_RESET = 8'd103;
  localparam logic [3:0] COOLDOWN_RELOAD = 4'd15;
  localparam logic [8:0] TICK_WRAP = 9'd300;
  localparam logic [13:0] CLAMP_MAX = 14'd9999;

  // one classified tick handed from front to back
  typedef struct packed {
    logic [3:0]  edges;        // rising button edges
    logic        sample;       // sample slot with good frame
    logic        report;       // report slot
    logic        cool_tick;    // cooldown decrement point after this tick
    logic [9:0]  humidity;
    logic [11:0] temperature;
  } tick_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_DIGITS
  } emit_state_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       humidifier_on;
    logic       heater_on;
    logic       last_of_tick;
  } result_t;

  function automatic logic [15:0] preset_limit(input logic [1:0] p, input logic [1:0] k);
    logic [15:0] v;
    begin
      v = 16'd0;
      case ({p, k})
        4'h0: v = 16'd800; 4'h1: v = 16'd900; 4'h2: v = 16'd270; 4'h3: v = 16'd300;
        4'h4: v = 16'd700; 4'h5: v = 16'd800; 4'h6: v = 16'd260; 4'h7: v = 16'd290;
        4'h8: v = 16'd600; 4'h9: v = 16'd750; 4'hA: v = 16'd250; 4'hB: v = 16'd300;
        4'hC: v = 16'd500; 4'hD: v = 16'd650; 4'hE: v = 16'd240; default: v = 16'd300;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== sv/climate_relay_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// climate_relay_controller
// tick-driven preset, relay and serial report controller
// ----------------------------------------------------------------------------
// Input queue: one beat per 100 ms tick, taken when push is high and full low.
// Result queue: each tick yields 1 to 26 result beats, the last flagged by
// last_of_tick; a beat leaves when pop is high and empty low.
// A front stage registers edges, tick slot and converted sample, and a
// one-entry queue hands the tick to the back sequencer, which applies relay
// logic on load and then emits the tick's byte beats in order.
// The back stage loads a tick while idle, then emits its edge messages and,
// after a step with no beat, the report digits. The front can take the
// next tick while the back still emits the previous. When the receiver
// stalls the output register holds and the back stage stops; the front
// stops once its one-entry queue holds a tick.
// Reset clears tick count, presets, cooldown (to 15), relays and the mask
// key (to 103); the block is ready the cycle after reset drops.
// mask_key is at address 0 of the APB port.
// ----------------------------------------------------------------------------
module climate_relay_controller import crc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  buttons,
  input  logic        sensor_ack,
  input  logic [7:0]  sensor_status,
  input  logic [19:0] raw_humidity,
  input  logic [19:0] raw_temperature,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  tx_byte,
  output logic        tx_valid,
  output logic        humidifier_on,
  output logic        heater_on,
  output logic        last_of_tick,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] mask_key;
  logic       in_ready, q_valid, q_ready, r_valid;
  tick_t      q_tick;
  result_t    r_data;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {24'd0, mask_key} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) mask_key <= MASK_RESET;
    else if (psel && penable && pwrite && paddr == 1'b0) mask_key <= pwdata[7:0];
  end

  assign full = !in_ready;

  crc_front u_front (
    .clk, .rst, .in_valid(push), .in_ready, .buttons, .sensor_ack, .sensor_status,
    .raw_humidity, .raw_temperature, .q_valid, .q_ready, .q_tick
  );

  crc_back u_back (
    .clk, .rst, .mask_key, .q_valid, .q_ready, .q_tick,
    .r_valid, .r_ready(pop), .r_data
  );

  assign empty         = !r_valid;
  assign tx_byte       = r_data.tx_byte;
  assign tx_valid      = r_data.tx_valid;
  assign humidifier_on = r_data.humidifier_on;
  assign heater_on     = r_data.heater_on;
  assign last_of_tick  = r_data.last_of_tick;

endmodule

// ===== sv/crc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_front
// edge detection, tick counting and sample conversion of each input beat
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc_front import crc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  buttons,
  input  logic        sensor_ack,
  input  logic [7:0]  sensor_status,
  input  logic [19:0] raw_humidity,
  input  logic [19:0] raw_temperature,
  output logic        q_valid,
  input  logic        q_ready,
  output tick_t       q_tick
);

  logic [8:0] tick_count;
  logic [3:0] prev_buttons;
  logic [5:0] mod50;
  logic [3:0] mod10;
  logic       half;        // odd multiple of 50 within hundred
  logic [8:0] tick_count_next;
  logic [29:0] h_prod;
  logic [30:0] t_prod;
  logic        fire;

  assign in_ready = !q_valid || q_ready;
  assign fire = in_valid && in_ready;
  assign tick_count_next = (tick_count == TICK_WRAP - 9'd1) ? 9'd0 : tick_count + 9'd1;
  assign h_prod = raw_humidity * 10'd1000;
  assign t_prod = raw_temperature * 11'd2000;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= 9'd0;
      prev_buttons <= 4'hF;
      mod50        <= 6'd0;
      mod10        <= 4'd0;
      half         <= 1'b0;
      q_valid      <= 1'b0;
    end else begin
      if (q_ready) q_valid <= 1'b0;
      if (fire) begin
        q_valid      <= 1'b1;
        tick_count   <= tick_count_next;
        prev_buttons <= buttons;
        mod10 <= (mod10 == 4'd9) ? 4'd0 : mod10 + 4'd1;
        if (mod50 == 6'd49) begin
          mod50 <= 6'd0;
          half  <= !half;
        end else begin
          mod50 <= mod50 + 6'd1;
        end
        if (tick_count_next == 9'd0) begin
          mod50 <= 6'd0;
          mod10 <= 4'd0;
          half  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      q_tick.edges       <= buttons & ~prev_buttons;
      q_tick.sample      <= (mod50 == 6'd0) && sensor_ack && !sensor_status[7];
      q_tick.report      <= (mod50 == 6'd0) && !half;
      q_tick.cool_tick   <= (mod10 == 4'd9) || (tick_count_next == 9'd0);
      q_tick.humidity    <= h_prod[29:20];
      q_tick.temperature <= 12'(t_prod[30:20]) - 12'd500;
    end
  end

  `ASSERT_ALWAYS(a_count_range, tick_count < TICK_WRAP, "tick count out of range")
  `ASSERT_ALWAYS(a_mod50_range, mod50 < 6'd50, "mod50 out of range")
  `ASSERT_ALWAYS(a_mod10_range, mod10 < 4'd10, "mod10 out of range")

endmodule

// ===== sv/crc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_back
// relay control and byte sequencing of each classified tick
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc_back import crc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] mask_key,
  input  logic       q_valid,
  output logic       q_ready,
  input  tick_t      q_tick,
  output logic       r_valid,
  input  logic       r_ready,
  output result_t    r_data
);

  emit_state_t state, state_next;
  logic [1:0]  active_preset;
  logic [3:0]  cooldown;
  logic        hum_relay, temp_relay;
  logic [11:0] held_temperature;
  logic [9:0]  held_humidity;
  logic        cur_report;
  logic [3:0]  edges_left;
  logic [1:0]  sub;        // byte within an edge message
  logic [3:0]  didx;       // report byte index 0..9
  logic [13:0] rem;        // part of the report value not yet sent
  logic [27:0] quot_prod;
  logic [3:0]  digit;
  logic [13:0] digit_weight;
  logic        load_tick;
  logic        out_free;
  logic [1:0]  cur_p;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        emit_go;
  logic [15:0] lim0, lim1, lim2, lim3;
  logic [1:0]  new_preset;
  logic [13:0] t_val, h_val;

  assign out_free = !r_valid || r_ready;

  // lowest pending edge
  always_comb begin
    cur_p = 2'd0;
    for (int i = 3; i >= 0; i--) if (edges_left[i]) cur_p = 2'(i);
  end

  // final preset for this tick: highest edge wins
  always_comb begin
    new_preset = active_preset;
    for (int i = 0; i < 4; i++) if (q_tick.edges[i]) new_preset = 2'(i);
  end

  assign lim0 = preset_limit(new_preset, 2'd0);
  assign lim1 = preset_limit(new_preset, 2'd1);
  assign lim2 = preset_limit(new_preset, 2'd2);
  assign lim3 = preset_limit(new_preset, 2'd3);

  assign t_val = held_temperature[11] ? CLAMP_MAX : 14'(held_temperature);
  assign h_val = (14'(held_humidity) > CLAMP_MAX) ? CLAMP_MAX : 14'(held_humidity);

  // one digit per beat, most significant first; reciprocal multiply bar units
  always_comb begin
    quot_prod    = 28'd0;
    digit        = 4'd0;
    digit_weight = 14'd1;
    case (didx[1:0])
      2'd0: begin
        quot_prod    = 28'(rem) * 28'd8389;
        digit        = quot_prod[26:23];
        digit_weight = 14'd1000;
      end
      2'd1: begin
        quot_prod    = 28'(rem) * 28'd41;
        digit        = quot_prod[15:12];
        digit_weight = 14'd100;
      end
      2'd2: begin
        quot_prod    = 28'(rem) * 28'd205;
        digit        = quot_prod[14:11];
        digit_weight = 14'd10;
      end
      default: begin
        digit        = rem[3:0];
        digit_weight = 14'd1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_valid) state_next = ST_EMIT;
      ST_EMIT:   if (out_free && emit_last) state_next = ST_IDLE;
                 else if (out_free && edges_left == 4'd0 && sub == 2'd0 && cur_report)
                   state_next = ST_DIGITS;
      ST_DIGITS: if (out_free && didx == 4'd9) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_byte = 8'd0;
    emit_last = 1'b0;
    emit_go   = 1'b0;
    q_ready   = 1'b0;
    unique case (state)
      ST_IDLE: q_ready = 1'b1;
      ST_EMIT: begin
        emit_go = edges_left != 4'd0;
        if (edges_left != 4'd0) begin
          case (sub)
            2'd0: emit_byte = CHAR_M;
            2'd1: emit_byte = CHAR_1 + 8'(cur_p);
            2'd2: emit_byte = CHAR_CR;
            default: emit_byte = CHAR_LF;
          endcase
          emit_last = !cur_report && sub == 2'd3 && $countones(edges_left) == 1;
        end else begin
          emit_last = !cur_report;
          emit_go   = !cur_report;
        end
      end
      ST_DIGITS: begin
        emit_go = 1'b1;
        if (didx == 4'd8) emit_byte = CHAR_CR;
        else if (didx == 4'd9) emit_byte = CHAR_LF;
        else emit_byte = (CHAR_0 | 8'(digit)) ^ mask_key;
        emit_last = didx == 4'd9;
      end
      default: ;
    endcase
  end

  assign load_tick = state == ST_IDLE && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active_preset <= 2'd0;
      cooldown      <= COOLDOWN_RELOAD;
      hum_relay     <= 1'b0;
      temp_relay    <= 1'b0;
      held_temperature <= 12'd0;
      held_humidity    <= 10'd0;
      r_valid       <= 1'b0;
      edges_left    <= 4'd0;
      sub           <= 2'd0;
      didx          <= 4'd0;
    end else begin
      state <= state_next;
      if (r_ready) r_valid <= 1'b0;
      if (load_tick) begin
        cur_report <= q_tick.report;
        edges_left <= q_tick.edges;
        sub        <= 2'd0;
        didx       <= 4'd0;
        active_preset <= new_preset;
        if (q_tick.sample) begin
          held_humidity    <= q_tick.humidity;
          held_temperature <= q_tick.temperature;
          if (16'(q_tick.humidity) < lim0) begin
            if (cooldown == 4'd0) hum_relay <= 1'b1;
          end else if (16'(q_tick.humidity) > lim1 && hum_relay) begin
            hum_relay <= 1'b0;
          end
          if ($signed(q_tick.temperature) < $signed(13'(lim2))) temp_relay <= 1'b1;
          else if ($signed(q_tick.temperature) >= $signed(13'(lim3))) temp_relay <= 1'b0;
        end
        // cooldown after relay decision
        if (q_tick.sample && !(16'(q_tick.humidity) < lim0) &&
            16'(q_tick.humidity) > lim1 && hum_relay) begin
          cooldown <= q_tick.cool_tick ? COOLDOWN_RELOAD - 4'd1 : COOLDOWN_RELOAD;
        end else if (q_tick.cool_tick && cooldown != 4'd0) begin
          cooldown <= cooldown - 4'd1;
        end
      end
      if (out_free && emit_go) begin
        r_valid <= 1'b1;
        r_data  <= '{tx_byte: emit_byte, tx_valid: emit_byte != 8'd0 || state == ST_DIGITS ||
                     edges_left != 4'd0, humidifier_on: hum_relay, heater_on: temp_relay,
                     last_of_tick: emit_last};
        if (state == ST_EMIT && edges_left != 4'd0) begin
          sub <= sub + 2'd1;
          if (sub == 2'd3) edges_left[cur_p] <= 1'b0;
        end
        if (state == ST_DIGITS) begin
          didx <= didx + 4'd1;
          if (didx == 4'd3) rem <= h_val;
          else rem <= rem - digit_weight * 14'(digit);
        end
      end
      if (state == ST_EMIT && state_next == ST_DIGITS) rem <= t_val;
    end
  end

  `ASSERT_NEXT(a_load_leaves_idle, load_tick, state != ST_IDLE, "tick not started")
  `ASSERT_ALWAYS(a_idle_no_edges, state != ST_IDLE || edges_left == 4'd0, "edges pending")
  `ASSERT_ALWAYS(a_didx_range, state != ST_DIGITS || didx <= 4'd9, "report index overrun")
  `ASSERT_NEXT(a_beat_held, r_valid && !r_ready, r_valid, "result beat dropped")

endmodule

// ===== sim/climate_relay_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// climate_relay_controller_test
// drives 100 ms ticks into the relay controller and checks every result beat
// against an in-bench model of presets, sampling, relays and masked reports;
// the mask key is rewritten between phases and both handshakes stall at random
// ----------------------------------------------------------------------------
module climate_relay_controller_test import crc_pkg::*; ();

  class tick_scoreboard;
    logic [7:0]  mask;
    int          tick_no;
    logic [3:0]  last_buttons;
    logic [1:0]  preset;
    int          cool;
    logic        hum_on;
    logic        heat_on;
    int          temp_tenths;
    int          hum_tenths;
    result_t     expected_beats[$];
    int          errors;

    function void clear();
      mask = MASK_RESET;
      tick_no = 0;
      last_buttons = 4'hF;
      preset = 2'd0;
      cool = 15;
      hum_on = 1'b0;
      heat_on = 1'b0;
      temp_tenths = 0;
      hum_tenths = 0;
      expected_beats.delete();
      errors = 0;
    endfunction

    function void add_digits(ref logic [7:0] bytes[$], input int v);
      if (v > 9999) v = 9999;
      bytes.push_back(8'('h30 + v / 1000) ^ mask);
      bytes.push_back(8'('h30 + (v / 100) % 10) ^ mask);
      bytes.push_back(8'('h30 + (v / 10) % 10) ^ mask);
      bytes.push_back(8'('h30 + v % 10) ^ mask);
    endfunction

    function void note_tick(logic [3:0] btn, logic ack, logic [7:0] status,
                            logic [19:0] rh, logic [19:0] rt);
      logic [7:0] bytes[$];
      longint     wide;
      int         lo_h, hi_h, lo_t, hi_t;
      result_t    r;
      for (int p = 0; p < 4; p++) begin
        if (!last_buttons[p] && btn[p]) begin
          preset = 2'(p);
          bytes.push_back(CHAR_M);
          bytes.push_back(CHAR_1 + 8'(p));
          bytes.push_back(CHAR_CR);
          bytes.push_back(CHAR_LF);
        end
      end
      last_buttons = btn;
      if (tick_no % 50 == 0 && ack && !status[7]) begin
        case (preset)
          0: begin lo_h = 800; hi_h = 900; lo_t = 270; hi_t = 300; end
          1: begin lo_h = 700; hi_h = 800; lo_t = 260; hi_t = 290; end
          2: begin lo_h = 600; hi_h = 750; lo_t = 250; hi_t = 300; end
          default: begin lo_h = 500; hi_h = 650; lo_t = 240; hi_t = 300; end
        endcase
        wide = longint'(rh) * 1000;
        hum_tenths = int'(wide >> 20);
        wide = longint'(rt) * 2000;
        temp_tenths = int'(wide >> 20) - 500;
        if (hum_tenths < lo_h) begin
          if (cool == 0) hum_on = 1'b1;
        end else if (hum_tenths > hi_h && hum_on) begin
          hum_on = 1'b0;
          cool = 15;
        end
        if (temp_tenths < lo_t) heat_on = 1'b1;
        else if (temp_tenths >= hi_t) heat_on = 1'b0;
      end
      if (tick_no % 100 == 0) begin
        add_digits(bytes, temp_tenths < 0 ? 9999 : temp_tenths);
        add_digits(bytes, hum_tenths);
        bytes.push_back(CHAR_CR);
        bytes.push_back(CHAR_LF);
      end
      tick_no = (tick_no + 1) % 300;
      if (tick_no % 10 == 0 && cool > 0) cool--;
      r.humidifier_on = hum_on;
      r.heater_on = heat_on;
      if (bytes.size() == 0) begin
        r.tx_byte = 8'd0;
        r.tx_valid = 1'b0;
        r.last_of_tick = 1'b1;
        expected_beats.push_back(r);
      end
      foreach (bytes[k]) begin
        r.tx_byte = bytes[k];
        r.tx_valid = 1'b1;
        r.last_of_tick = (k == bytes.size() - 1);
        expected_beats.push_back(r);
      end
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte expected %0h got %0h", want.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.tx_valid !== want.tx_valid) begin
        $error("tx_valid expected %0b got %0b", want.tx_valid, got.tx_valid);
        errors++;
      end
      if (got.humidifier_on !== want.humidifier_on) begin
        $error("humidifier_on expected %0b got %0b", want.humidifier_on, got.humidifier_on);
        errors++;
      end
      if (got.heater_on !== want.heater_on) begin
        $error("heater_on expected %0b got %0b", want.heater_on, got.heater_on);
        errors++;
      end
      if (got.last_of_tick !== want.last_of_tick) begin
        $error("last_of_tick expected %0b got %0b", want.last_of_tick, got.last_of_tick);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        full;
  logic [3:0]  buttons = 0;
  logic        sensor_ack = 0;
  logic [7:0]  sensor_status = 0;
  logic [19:0] raw_humidity = 0;
  logic [19:0] raw_temperature = 0;
  logic        empty;
  logic        pop = 0;
  logic [7:0]  tx_byte;
  logic        tx_valid;
  logic        humidifier_on;
  logic        heater_on;
  logic        last_of_tick;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic        paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  tick_scoreboard sb = new();
  bit steady = 0;        // no idling on either side
  bit hold_request = 0;  // ask the receiver for a long hold-off
  int cycles = 0;

  climate_relay_controller dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // monitors: sample at the edge, before this edge's drives land
  always @(posedge clk) begin
    if (!rst && push && !full)
      sb.note_tick(buttons, sensor_ack, sensor_status, raw_humidity, raw_temperature);
    if (!rst && pop && !empty)
      sb.check_beat('{tx_byte, tx_valid, humidifier_on, heater_on, last_of_tick});
  end

  // receiver
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        pop <= 0;
        stall_left--;
      end else begin
        pop <= 1;
        if (!steady && $urandom_range(0, 99) < 20)
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  function int sender_gap();
    if (steady || $urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 40);
    return $urandom_range(1, 3);
  endfunction

  task send_tick(logic [3:0] b, logic a, logic [7:0] s, logic [19:0] h, logic [19:0] t,
                 int gap);
    push <= 1;
    buttons <= b;
    sensor_ack <= a;
    sensor_status <= s;
    raw_humidity <= h;
    raw_temperature <= t;
    do @(posedge clk); while (full);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task write_mask(logic [7:0] v);
    push <= 0;
    @(posedge clk);
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= 0;
    pwdata <= {16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)), v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.mask = v;
  endtask

  task random_ticks(int count);
    logic [3:0]  b;
    logic [7:0]  s;
    logic [19:0] h, t;
    for (int i = 0; i < count; i++) begin
      b = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : sb.last_buttons;
      s = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) != 0) s[7] = 0;
      // near the limits most of the time on sample ticks
      if (sb.tick_no % 50 == 0 && $urandom_range(0, 3) != 0) begin
        h = 20'($urandom_range(450000, 1000000));
        t = 20'($urandom_range(360000, 450000));
      end else begin
        h = 20'($urandom_range(0, 20'hFFFFF));
        t = 20'($urandom_range(0, 20'hFFFFF));
      end
      send_tick(b, $urandom_range(0, 9) != 0, s, h, t, sender_gap());
    end
  endtask

  initial begin
    sb.clear();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // report with negative temperature, then edge cases on buttons
    send_tick(4'hF, 1, 8'h00, 20'hFFFFF, 20'h00000, 0);
    send_tick(4'h0, 1, 8'h7F, 20'h00000, 20'hFFFFF, 0);
    send_tick(4'hF, 0, 8'hFF, 20'hFFFFF, 20'hFFFFF, 1);
    send_tick(4'h0, 1, 8'h00, 20'h00000, 20'h00000, 0);
    send_tick(4'h1, 1, 8'h00, 20'h00000, 20'h00000, 0);
    send_tick(4'h2, 1, 8'h00, 20'h00000, 20'h00000, 2);
    send_tick(4'h4, 1, 8'h00, 20'h00000, 20'h00000, 0);
    send_tick(4'h8, 1, 8'h00, 20'h00000, 20'h00000, 0);
    send_tick(4'h5, 1, 8'h80, 20'hAAAAA, 20'h55555, 0);
    send_tick(4'hA, 1, 8'h00, 20'h55555, 20'hAAAAA, 0);
    send_tick(4'h8, 1, 8'h00, 20'h00000, 20'h00000, 0);
    write_mask(8'h00);
    hold_request = 1;
    random_ticks(90);
    write_mask(8'hFF);
    steady = 1;
    random_ticks(60);
    steady = 0;
    random_ticks(40);
    write_mask(8'($urandom_range(1, 254)));
    random_ticks(60);
    push <= 0;
    @(posedge clk);
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
